/* rtl/core/atem_pkg.sv */
// Shared types and constants for the two-effect audio mixer.
package atem_pkg;

   localparam int SAMPLE_W     = 16;
   localparam int LOAD_W       = 12;
   localparam int LEN_W        = 13;
   localparam int MODE_W       = 3;
   localparam int CSR_IDX_W    = 1;
   localparam int EFFECT_DEPTH = 4096;

   localparam logic signed [SAMPLE_W-1:0] MIX_MAX = 16'sh7FFF;
   localparam logic signed [SAMPLE_W-1:0] MIX_MIN = 16'sh8000;

   typedef enum logic [MODE_W-1:0] {
      MODE_MUSIC  = 3'd0,
      MODE_LOAD_A = 3'd1,
      MODE_LOAD_B = 3'd2,
      MODE_TRIG_A = 3'd3,
      MODE_TRIG_B = 3'd4
   } mode_type;

   localparam logic [CSR_IDX_W-1:0] CSR_EFFECT_A_LENGTH = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_EFFECT_B_LENGTH = 1'd1;

   // Per-transaction strobes from the top level to one effect channel.
   typedef struct packed {
      logic len_we;
      logic load;
      logic trig;
      logic step;
   } atem_ctl_type;

endpackage

/* rtl/core/audio_two_effect_mixer_top.sv */
// Top level of the two-effect audio mixer: handshakes, register decode and saturating mix.
//
// Channel | Direction | Payload
// req     | in        | tuser: mode[2:0]; tdata: sample[15:0], load_index[27:16]
// rsp     | out       | tdata: mixed_sample[15:0], effect_a_playing[16], effect_b_playing[17]
// csr     | in        | csr_index selects the length register, csr_data is the new length
//
// One transaction is taken every cycle while req_tready is high. The effect memories are
// read at the edge that accepts a music sample, and the add and saturation are registered
// into the output when the read stage advances, which waits while rsp is stalled.
// Reset is synchronous and clears positions, active flags, lengths and valids;
// the effect memories are not cleared and must be loaded before they are played.
// A stall on rsp backs up into the read stage and then lowers req_tready.
module audio_two_effect_mixer_top
   import atem_pkg::*;
#(
   parameter int EFFECT_DEPTH = atem_pkg::EFFECT_DEPTH
) (
   input  logic                 clock,
   input  logic                 reset,
   // Request stream.
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [MODE_W-1:0]    req_tuser,   // mode[2:0]
   input  logic [31:0]          req_tdata,   // sample[15:0], load_index[27:16]
   // Response stream.
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [23:0]          rsp_tdata,   // mixed_sample[15:0], a_playing[16], b_playing[17]
   // Register write channel.
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [LEN_W-1:0]     csr_data
);

   logic                       req_fire;
   logic                       csr_fire;
   logic signed [SAMPLE_W-1:0] req_sample;
   logic [LOAD_W-1:0]          req_load_index;
   atem_ctl_type               ctl_a, ctl_b;

   logic signed [SAMPLE_W-1:0] word_a, word_b;
   logic                       playing_a, playing_b;

   // Read stage: holds the music sample while the memories deliver their words.
   logic                       s1_valid_ff, s1_valid_in;
   logic signed [SAMPLE_W-1:0] s1_music_ff;
   logic                       s1_advance;

   // Output register.
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [23:0]                rsp_data_ff;

   logic signed [SAMPLE_W+1:0] sum;
   logic signed [SAMPLE_W-1:0] sat;

   assign csr_ready      = 1'b1;
   assign csr_fire       = csr_valid && csr_ready;
   assign req_sample     = req_tdata[15:0];
   assign req_load_index = req_tdata[27:16];

   assign s1_advance = s1_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !(s1_valid_ff && rsp_valid_ff && !rsp_tready);
   assign req_fire   = req_tvalid && req_tready;

   // Decode the mode of each accepted transaction into channel strobes.
   always_comb begin
      ctl_a        = '0;
      ctl_b        = '0;
      ctl_a.len_we = csr_fire && (csr_index == CSR_EFFECT_A_LENGTH);
      ctl_b.len_we = csr_fire && (csr_index == CSR_EFFECT_B_LENGTH);
      if (req_fire) begin
         case (req_tuser)
            MODE_MUSIC: begin
               ctl_a.step = 1'b1;
               ctl_b.step = 1'b1;
            end
            MODE_LOAD_A: ctl_a.load = 1'b1;
            MODE_LOAD_B: ctl_b.load = 1'b1;
            MODE_TRIG_A: ctl_a.trig = 1'b1;
            MODE_TRIG_B: ctl_b.trig = 1'b1;
            default: ;
         endcase
      end
   end

   atem_effect #(.EFFECT_DEPTH(EFFECT_DEPTH)) u_effect_a (
      .clock      (clock),
      .reset      (reset),
      .ctl        (ctl_a),
      .len_data   (csr_data),
      .load_index (req_load_index),
      .load_data  (req_sample),
      .word       (word_a),
      .playing    (playing_a)
   );

   atem_effect #(.EFFECT_DEPTH(EFFECT_DEPTH)) u_effect_b (
      .clock      (clock),
      .reset      (reset),
      .ctl        (ctl_b),
      .len_data   (csr_data),
      .load_index (req_load_index),
      .load_data  (req_sample),
      .word       (word_b),
      .playing    (playing_b)
   );

   // The music is counted once; an idle effect contributes zero.
   assign sum = {{2{s1_music_ff[SAMPLE_W-1]}}, s1_music_ff}
              + {{2{word_a[SAMPLE_W-1]}}, word_a}
              + {{2{word_b[SAMPLE_W-1]}}, word_b};

   // Both sides of each compare are signed so negative sums order correctly.
   always_comb begin
      if (sum > $signed({{2{MIX_MAX[SAMPLE_W-1]}}, MIX_MAX})) begin
         sat = MIX_MAX;
      end else if (sum < $signed({{2{MIX_MIN[SAMPLE_W-1]}}, MIX_MIN})) begin
         sat = MIX_MIN;
      end else begin
         sat = sum[SAMPLE_W-1:0];
      end
   end

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (ctl_a.step) begin
         s1_valid_in = 1'b1;
      end else if (s1_advance) begin
         s1_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (s1_advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl_a.step) begin
         s1_music_ff <= req_sample;
      end
      if (s1_advance) begin
         rsp_data_ff <= {6'd0, playing_b, playing_a, sat};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

`ifndef ASSERT_OFF
   // Backpressure only arises when both the read stage and the output are full.
   a_ready_low: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> (s1_valid_ff && rsp_valid_ff && !rsp_tready))
      else $error("req_tready low without a full pipeline");

   // The read stage fills only from an accepted music transaction.
   a_s1_source: assert property (@(posedge clock) disable iff (reset)
      $rose(s1_valid_ff) |-> $past(req_fire && (req_tuser == MODE_MUSIC)))
      else $error("read stage filled without a music transaction");

   // A waiting read-stage item reaches the output once it is free.
   a_s1_moves: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !rsp_valid_ff) |=> rsp_valid_ff)
      else $error("read stage did not advance into an empty output");

   // A stalled response keeps its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_tready) |=> (rsp_valid_ff && $stable(rsp_data_ff)))
      else $error("stalled response changed");
`endif

endmodule

/* rtl/core/atem_effect.sv */
// One effect channel: sample memory, length register, play position and active flag.
module atem_effect
   import atem_pkg::*;
#(
   parameter int EFFECT_DEPTH = atem_pkg::EFFECT_DEPTH
) (
   input  logic                       clock,
   input  logic                       reset,
   input  atem_ctl_type               ctl,
   input  logic [LEN_W-1:0]           len_data,
   input  logic [LOAD_W-1:0]          load_index,
   input  logic signed [SAMPLE_W-1:0] load_data,
   output logic signed [SAMPLE_W-1:0] word,
   output logic                       playing
);

   localparam int AW = $clog2(EFFECT_DEPTH);
   localparam int LW = (AW + 1 > LEN_W) ? AW + 1 : LEN_W;
   localparam logic [LW-1:0] DEPTH_W = LW'(EFFECT_DEPTH);

   logic signed [SAMPLE_W-1:0] mem [EFFECT_DEPTH];

   logic [LEN_W-1:0]           len_ff;
   logic [AW-1:0]              pos_ff, pos_in;
   logic                       active_ff, active_in;
   logic signed [SAMPLE_W-1:0] rd_ff;
   logic                       used_ff;
   logic                       playing_ff;

   logic [LW-1:0] len_eff;
   logic [LW-1:0] len_wide;
   logic [LW-1:0] load_wide;
   logic [LW-1:0] pos_next;

   assign len_wide  = {{(LW-LEN_W){1'b0}}, len_ff};
   assign len_eff   = (len_wide > DEPTH_W) ? DEPTH_W : len_wide;
   assign load_wide = {{(LW-LOAD_W){1'b0}}, load_index};
   assign pos_next  = {{(LW-AW){1'b0}}, pos_ff} + 1'b1;

   always_comb begin
      pos_in    = pos_ff;
      active_in = active_ff;
      if (ctl.trig) begin
         if (len_eff != '0) begin
            active_in = 1'b1;
            pos_in    = '0;
         end
      end else if (ctl.step && active_ff) begin
         if (pos_next >= len_eff) begin
            active_in = 1'b0;
            pos_in    = '0;
         end else begin
            pos_in = pos_next[AW-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff    <= '0;
         pos_ff    <= '0;
         active_ff <= 1'b0;
      end else begin
         if (ctl.len_we) begin
            len_ff <= len_data;
         end
         pos_ff    <= pos_in;
         active_ff <= active_in;
      end
   end

   // A load and a read never fall in the same cycle, and a read in the cycle
   // after a load already sees the new word, so no forwarding is needed.
   always_ff @(posedge clock) begin
      if (ctl.load && (load_wide < DEPTH_W)) begin
         mem[load_wide[AW-1:0]] <= load_data;
      end
      if (ctl.step) begin
         rd_ff      <= mem[pos_ff];
         used_ff    <= active_ff;
         playing_ff <= active_in;
      end
   end

   assign word    = used_ff ? rd_ff : '0;
   assign playing = playing_ff;

endmodule
